// ----- design/rope_pkg.sv -----
// Shared types and constants of the rotary position embedding stream.
package rope_pkg;

	localparam int DEFAULT_MAX_DEPTH  = 256;
	localparam int DEFAULT_DATA_WIDTH = 16;

	// Fixed field widths.
	localparam int TRIG_W = 16;
	localparam int POS_W  = 16;
	localparam int IDX_W  = 8;
	localparam int CNT_W  = 9;
	localparam int INDEX_LIMIT = 256;

	// Q1.14 arithmetic.
	localparam int FRAC_BITS  = 14;
	localparam int ROUND_BIAS = 8192;
	localparam logic signed [TRIG_W-1:0] COS_ONE = 16'sd16384;

	// Configuration port.
	localparam int PADDR_W = 5;
	localparam int PDATA_W = 32;

	typedef enum logic [2:0] {
		REG_STEP  = 3'd0,
		REG_DEPTH = 3'd1,
		REG_WIDTH = 3'd2,
		REG_ROWS  = 3'd3,
		REG_MODE  = 3'd4
	} reg_idx_t;

	localparam logic [POS_W-1:0] RST_STEP  = 16'd0;
	localparam logic [CNT_W-1:0] RST_DEPTH = 9'd256;
	localparam logic [CNT_W-1:0] RST_WIDTH = 9'd0;
	localparam logic [POS_W-1:0] RST_ROWS  = 16'd1;
	localparam logic             RST_MODE  = 1'b0;

	typedef struct packed {
		logic [POS_W-1:0] step;
		logic [CNT_W-1:0] depth;
		logic [CNT_W-1:0] width;
		logic [POS_W-1:0] rows;
		logic             interleave;
	} cfg_t;

	// Queue between the front and the back part.
	localparam int QDEPTH = 4;
	localparam int QAW    = $clog2(QDEPTH);
	localparam int QCW    = $clog2(QDEPTH + 1);

	typedef struct packed {
		logic           head_valid;
		logic [QCW-1:0] level;
	} q_status_t;

	typedef enum logic {
		OP_PASS = 1'b0,
		OP_PAIR = 1'b1
	} op_kind_t;

	typedef enum logic {
		PH_LOWER = 1'b0,
		PH_UPPER = 1'b1
	} phase_t;

endpackage

// ----- design/rope_in_if.sv -----
// Input element channel: valid/ready handshake with element, sine, cosine and row offset.
interface rope_in_if
	import rope_pkg::*;
#(
	parameter int DATA_WIDTH = DEFAULT_DATA_WIDTH
);
	logic                         valid;
	logic                         ready;
	logic signed [DATA_WIDTH-1:0] elem_value;
	logic signed [TRIG_W-1:0]     sine_value;
	logic signed [TRIG_W-1:0]     cosine_value;
	logic [POS_W-1:0]             row_offset;

	modport source (output valid, elem_value, sine_value, cosine_value, row_offset,
		input ready);
	modport sink (input valid, elem_value, sine_value, cosine_value, row_offset,
		output ready);
endinterface

// ----- design/rope_out_if.sv -----
// Result channel: valid/ready handshake with value, indexes and end-of-run flag.
interface rope_out_if
	import rope_pkg::*;
#(
	parameter int DATA_WIDTH = DEFAULT_DATA_WIDTH
);
	logic                         valid;
	logic                         ready;
	logic signed [DATA_WIDTH-1:0] out_value;
	logic [IDX_W-1:0]             element_index;
	logic [POS_W-1:0]             time_index;
	logic                         last_of_run;

	modport source (output valid, out_value, element_index, time_index, last_of_run,
		input ready);
	modport sink (input valid, out_value, element_index, time_index, last_of_run,
		output ready);
endinterface

// ----- design/rope_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
module rope_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 128
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;
endmodule

// ----- design/rope_front.sv -----
// Front part: accepts elements, tracks element and time counters, stores first halves
// of pairs and hands pass and pair operations to the queue.
module rope_front
	import rope_pkg::*;
#(
	parameter int  MAX_DEPTH  = DEFAULT_MAX_DEPTH,
	parameter int  DATA_WIDTH = DEFAULT_DATA_WIDTH,
	parameter type op_t       = logic
) (
	input  logic      clk,
	input  logic      arst_n,
	rope_in_if.sink   elem,
	input  cfg_t      cfg,
	input  q_status_t qstat,
	output logic      push,
	output op_t       push_op
);
	localparam int LIMIT       = (MAX_DEPTH < INDEX_LIMIT) ? MAX_DEPTH : INDEX_LIMIT;
	localparam int STORE_DEPTH = LIMIT / 2;
	localparam int AW          = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
	localparam int SW          = DATA_WIDTH + 2 * TRIG_W;
	localparam logic [CNT_W-1:0] LIMIT_C = CNT_W'(LIMIT);
	localparam logic [CNT_W-1:0] MIN_DEPTH = CNT_W'(2);

	logic [IDX_W-1:0] elem_q;
	logic [POS_W-1:0] time_q;

	logic             s1_valid;
	op_kind_t         s1_kind;
	logic signed [DATA_WIDTH-1:0] s1_x;
	logic signed [TRIG_W-1:0]     s1_sn;
	logic signed [TRIG_W-1:0]     s1_cs;
	logic [IDX_W-1:0] s1_lo;
	logic [IDX_W-1:0] s1_hi;
	logic [POS_W-1:0] s1_time;

	logic [CNT_W-1:0] depth_eff;
	logic [CNT_W-1:0] width_raw;
	logic [CNT_W-1:0] width_eff;
	logic [IDX_W-1:0] half;
	logic [CNT_W-1:0] idx_ext;
	logic [POS_W+1:0] pos;
	logic             pos_neg;
	logic             is_pass;
	logic             store_cond;
	logic [IDX_W-1:0] lower_idx;
	logic             acc;
	logic             do_store;
	logic             do_push;
	logic [QCW:0]     in_flight;
	logic [POS_W-1:0] rows_eff;
	logic             row_end;
	logic             seq_end;

	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [AW-1:0] ram_raddr;
	logic [SW-1:0] ram_wdata;
	logic [SW-1:0] ram_rdata;

	// Credit check: the queue plus the operation in flight must leave room.
	assign in_flight  = {1'b0, qstat.level} + (QCW+1)'(s1_valid);
	assign elem.ready = in_flight < (QCW+1)'(QDEPTH);
	assign acc        = elem.valid & elem.ready;

	always_comb begin
		if (cfg.depth < MIN_DEPTH) begin
			depth_eff = MIN_DEPTH;
		end else if (cfg.depth > LIMIT_C) begin
			depth_eff = LIMIT_C;
		end else begin
			depth_eff = cfg.depth;
		end
		if (cfg.width == '0 || cfg.width > depth_eff) begin
			width_raw = depth_eff;
		end else begin
			width_raw = cfg.width;
		end
	end

	assign width_eff = {width_raw[CNT_W-1:1], 1'b0};
	assign half      = width_eff[CNT_W-1:1];
	assign idx_ext   = {1'b0, elem_q};

	// A row whose position is negative produces nothing but still advances the counters.
	assign pos     = (POS_W+2)'(time_q) + (POS_W+2)'(cfg.step) - (POS_W+2)'(elem.row_offset);
	assign pos_neg = pos[POS_W+1];
	assign is_pass = idx_ext >= width_eff;

	always_comb begin
		if (cfg.interleave) begin
			store_cond = ~elem_q[0];
			lower_idx  = {elem_q[IDX_W-1:1], 1'b0};
		end else begin
			store_cond = idx_ext < {1'b0, half};
			lower_idx  = elem_q - half;
		end
	end

	assign do_store  = acc & ~pos_neg & ~is_pass & store_cond;
	assign do_push   = acc & ~pos_neg & (is_pass | ~store_cond);
	assign ram_we    = do_store;
	assign ram_waddr = cfg.interleave ? '0 : elem_q[AW-1:0];
	assign ram_raddr = cfg.interleave ? '0 : lower_idx[AW-1:0];
	assign ram_wdata = {elem.elem_value, elem.sine_value, elem.cosine_value};

	rope_ram #(
		.WIDTH(SW),
		.DEPTH(STORE_DEPTH)
	) u_partner_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign rows_eff = (cfg.rows == '0) ? POS_W'(1) : cfg.rows;
	assign row_end  = (idx_ext + CNT_W'(1)) >= depth_eff;
	assign seq_end  = ({1'b0, time_q} + (POS_W+1)'(1)) >= {1'b0, rows_eff};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			elem_q   <= '0;
			time_q   <= '0;
			s1_valid <= 1'b0;
		end else begin
			s1_valid <= do_push;
			if (acc) begin
				if (row_end) begin
					elem_q <= '0;
					time_q <= seq_end ? '0 : time_q + POS_W'(1);
				end else begin
					elem_q <= elem_q + IDX_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			s1_kind <= is_pass ? OP_PASS : OP_PAIR;
			s1_x    <= elem.elem_value;
			s1_sn   <= elem.sine_value;
			s1_cs   <= elem.cosine_value;
			s1_lo   <= lower_idx;
			s1_hi   <= elem_q;
			s1_time <= time_q;
		end
	end

	// The partner read issued at acceptance lands in the RAM output register now.
	assign push = s1_valid;

	always_comb begin
		push_op          = '0;
		push_op.kind     = s1_kind;
		push_op.x        = s1_x;
		push_op.sn       = s1_sn;
		push_op.cs       = s1_cs;
		push_op.pv       = ram_rdata[SW-1 -: DATA_WIDTH];
		push_op.ps       = ram_rdata[2*TRIG_W-1 -: TRIG_W];
		push_op.pc       = ram_rdata[TRIG_W-1:0];
		push_op.idx_lo   = s1_lo;
		push_op.idx_hi   = s1_hi;
		push_op.time_idx = s1_time;
	end
endmodule

// ----- design/rope_queue.sv -----
// Short FIFO of pending operations between the front and the back part.
module rope_queue
	import rope_pkg::*;
#(
	parameter type op_t = logic
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  op_t       push_op,
	input  logic      pop,
	output op_t       head,
	output q_status_t qstat
);
	op_t            mem_q [QDEPTH];
	logic [QAW-1:0] wr_ptr_q;
	logic [QAW-1:0] rd_ptr_q;
	logic [QCW-1:0] level_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QAW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QAW'(1);
			end
			unique case ({push, pop})
				2'b10: begin
					level_q <= level_q + QCW'(1);
				end
				2'b01: begin
					level_q <= level_q - QCW'(1);
				end
				default: begin
					level_q <= level_q;
				end
			endcase
		end
	end

	assign head             = mem_q[rd_ptr_q];
	assign qstat.head_valid = level_q != '0;
	assign qstat.level      = level_q;
endmodule

// ----- design/rope_back.sv -----
// Back part: turns queued operations into results, two per pair, through a multiply
// stage and a round-and-saturate output register.
module rope_back
	import rope_pkg::*;
#(
	parameter int  DATA_WIDTH = DEFAULT_DATA_WIDTH,
	parameter type op_t       = logic
) (
	input  logic      clk,
	input  logic      arst_n,
	input  q_status_t qstat,
	input  op_t       head,
	output logic      pop,
	rope_out_if.source result
);
	localparam int PW    = DATA_WIDTH + TRIG_W;
	localparam int SUM_W = DATA_WIDTH + TRIG_W + 2;
	localparam int QW    = SUM_W - FRAC_BITS;
	localparam logic signed [SUM_W-1:0] ROUND = SUM_W'(ROUND_BIAS);
	localparam logic signed [QW-1:0] SAT_HI =
		{{(QW-DATA_WIDTH+1){1'b0}}, {(DATA_WIDTH-1){1'b1}}};
	localparam logic signed [QW-1:0] SAT_LO = ~SAT_HI;

	phase_t phase_q;
	phase_t phase_d;

	logic issue;
	logic p_free;
	logic o_free;

	logic signed [DATA_WIDTH-1:0] own;
	logic signed [DATA_WIDTH-1:0] partner;
	logic signed [TRIG_W-1:0]     sin_sel;
	logic signed [TRIG_W-1:0]     cos_sel;
	logic                         neg_sel;
	logic [IDX_W-1:0]             idx_sel;
	logic                         last_sel;

	logic                 p_valid_s1;
	logic signed [PW-1:0] p_a_s1;
	logic signed [PW-1:0] p_b_s1;
	logic                 p_neg_s1;
	logic [IDX_W-1:0]     p_idx_s1;
	logic [POS_W-1:0]     p_time_s1;
	logic                 p_last_s1;

	logic signed [SUM_W-1:0] sum;
	logic signed [QW-1:0]    quo;
	logic signed [DATA_WIDTH-1:0] sat;

	logic                         o_valid_q;
	logic signed [DATA_WIDTH-1:0] o_value_q;
	logic [IDX_W-1:0]             o_idx_q;
	logic [POS_W-1:0]             o_time_q;
	logic                         o_last_q;

	assign o_free = ~o_valid_q | result.ready;
	assign p_free = ~p_valid_s1 | o_free;
	assign issue  = qstat.head_valid & p_free;

	always_comb begin
		phase_d = phase_q;
		unique case (phase_q)
			PH_LOWER: begin
				if (issue && head.kind == OP_PAIR) begin
					phase_d = PH_UPPER;
				end
			end
			PH_UPPER: begin
				if (issue) begin
					phase_d = PH_LOWER;
				end
			end
			default: begin
				phase_d = PH_LOWER;
			end
		endcase
	end

	// Operand selection: the lower result of a pair subtracts its partner's term.
	// A passed element is multiplied by one so it follows the same path.
	always_comb begin
		pop      = 1'b0;
		own      = head.x;
		partner  = '0;
		sin_sel  = '0;
		cos_sel  = COS_ONE;
		neg_sel  = 1'b0;
		idx_sel  = head.idx_hi;
		last_sel = 1'b1;
		unique case (phase_q)
			PH_LOWER: begin
				if (head.kind == OP_PAIR) begin
					own      = head.pv;
					partner  = head.x;
					sin_sel  = head.ps;
					cos_sel  = head.pc;
					neg_sel  = 1'b1;
					idx_sel  = head.idx_lo;
					last_sel = 1'b0;
				end else begin
					pop = issue;
				end
			end
			PH_UPPER: begin
				own     = head.x;
				partner = head.pv;
				sin_sel = head.sn;
				cos_sel = head.cs;
				pop     = issue;
			end
			default: begin
				pop = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_LOWER;
			p_valid_s1 <= 1'b0;
			o_valid_q  <= 1'b0;
		end else begin
			phase_q <= phase_d;
			if (p_free) begin
				p_valid_s1 <= issue;
			end
			if (o_free) begin
				o_valid_q <= p_valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			p_a_s1    <= own * cos_sel;
			p_b_s1    <= partner * sin_sel;
			p_neg_s1  <= neg_sel;
			p_idx_s1  <= idx_sel;
			p_time_s1 <= head.time_idx;
			p_last_s1 <= last_sel;
		end
	end

	// Floor of the biased sum gives rounding to nearest with ties toward plus infinity.
	always_comb begin
		if (p_neg_s1) begin
			sum = SUM_W'(p_a_s1) - SUM_W'(p_b_s1) + ROUND;
		end else begin
			sum = SUM_W'(p_a_s1) + SUM_W'(p_b_s1) + ROUND;
		end
		quo = $signed(sum[SUM_W-1:FRAC_BITS]);
		if (quo > SAT_HI) begin
			sat = SAT_HI[DATA_WIDTH-1:0];
		end else if (quo < SAT_LO) begin
			sat = SAT_LO[DATA_WIDTH-1:0];
		end else begin
			sat = quo[DATA_WIDTH-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (o_free && p_valid_s1) begin
			o_value_q <= sat;
			o_idx_q   <= p_idx_s1;
			o_time_q  <= p_time_s1;
			o_last_q  <= p_last_s1;
		end
	end

	assign result.valid         = o_valid_q;
	assign result.out_value     = o_value_q;
	assign result.element_index = o_idx_q;
	assign result.time_index    = o_time_q;
	assign result.last_of_run   = o_last_q;
endmodule

// ----- design/rotary_position_embedding_stream.sv -----
// Top level of the rotary position embedding stream with its register port.
//
//   channel  direction  handshake                      payload
//   elem     in         elem.valid / elem.ready        elem_value, sine_value, cosine_value,
//                                                      row_offset
//   result   out        result.valid / result.ready    out_value, element_index, time_index,
//                                                      last_of_run
//   apb      in         psel, penable, pwrite, pready  paddr, pwdata, prdata
//
// Elements are accepted one per cycle while the queue has room; the back part turns out one
// result per cycle while the output is not stalled, so a pair holds it for both results.
// Interleave mode then averages one element per cycle, but in half mode the second half of
// a rotated row is accepted only as fast as the back part drains its pairs once the queue
// has filled. A result passes the front stage, queue, multiply stage and output register.
// Reset loads the register defaults and clears the counters and queue; acceptance stalls
// when the queued operations plus the one in the front stage reach four.
module rotary_position_embedding_stream
	import rope_pkg::*;
#(
	parameter int MAX_DEPTH  = DEFAULT_MAX_DEPTH,
	parameter int DATA_WIDTH = DEFAULT_DATA_WIDTH
) (
	input  logic               clk,
	input  logic               arst_n,
	rope_in_if.sink            elem,
	rope_out_if.source         result,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready
);
	typedef struct packed {
		op_kind_t                     kind;
		logic signed [DATA_WIDTH-1:0] x;
		logic signed [TRIG_W-1:0]     sn;
		logic signed [TRIG_W-1:0]     cs;
		logic signed [DATA_WIDTH-1:0] pv;
		logic signed [TRIG_W-1:0]     ps;
		logic signed [TRIG_W-1:0]     pc;
		logic [IDX_W-1:0]             idx_lo;
		logic [IDX_W-1:0]             idx_hi;
		logic [POS_W-1:0]             time_idx;
	} op_t;

	cfg_t      cfg_q;
	reg_idx_t  reg_sel;
	logic      wr_en;
	logic      push;
	logic      pop;
	op_t       push_op;
	op_t       head;
	q_status_t qstat;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite & pready;
	assign reg_sel = reg_idx_t'(paddr[PADDR_W-1:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.step       <= RST_STEP;
			cfg_q.depth      <= RST_DEPTH;
			cfg_q.width      <= RST_WIDTH;
			cfg_q.rows       <= RST_ROWS;
			cfg_q.interleave <= RST_MODE;
		end else if (wr_en) begin
			unique case (reg_sel)
				REG_STEP:  cfg_q.step       <= pwdata[POS_W-1:0];
				REG_DEPTH: cfg_q.depth      <= pwdata[CNT_W-1:0];
				REG_WIDTH: cfg_q.width      <= pwdata[CNT_W-1:0];
				REG_ROWS:  cfg_q.rows       <= pwdata[POS_W-1:0];
				REG_MODE:  cfg_q.interleave <= pwdata[0];
				default: begin
					cfg_q <= cfg_q;
				end
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			REG_STEP:  prdata = PDATA_W'(cfg_q.step);
			REG_DEPTH: prdata = PDATA_W'(cfg_q.depth);
			REG_WIDTH: prdata = PDATA_W'(cfg_q.width);
			REG_ROWS:  prdata = PDATA_W'(cfg_q.rows);
			REG_MODE:  prdata = PDATA_W'(cfg_q.interleave);
			default:   prdata = '0;
		endcase
	end

	rope_front #(
		.MAX_DEPTH (MAX_DEPTH),
		.DATA_WIDTH(DATA_WIDTH),
		.op_t      (op_t)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.elem   (elem),
		.cfg    (cfg_q),
		.qstat  (qstat),
		.push   (push),
		.push_op(push_op)
	);

	rope_queue #(
		.op_t(op_t)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.push_op(push_op),
		.pop    (pop),
		.head   (head),
		.qstat  (qstat)
	);

	rope_back #(
		.DATA_WIDTH(DATA_WIDTH),
		.op_t      (op_t)
	) u_back (
		.clk   (clk),
		.arst_n(arst_n),
		.qstat (qstat),
		.head  (head),
		.pop   (pop),
		.result(result)
	);

`ifndef ASSERT_OFF
	// The credit check in the front must keep the queue from overflowing.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> qstat.level < QCW'(QDEPTH))
		else $error("operation pushed into a full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> qstat.head_valid)
		else $error("operation popped from an empty queue");

	a_ready_credit: assert property (@(posedge clk) disable iff (!arst_n)
		elem.ready |-> qstat.level < QCW'(QDEPTH))
		else $error("element offered ready while the queue is full");
`endif
endmodule

// ----- test/tb_top.sv -----
// Self-checking testbench for the rotary position embedding stream: directed table, then random phases.
module tb_top;
	import rope_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int BY_PREDICTOR   = -1;
	localparam int SETTLE_CYCLES  = 10;
	localparam int TAIL_CYCLES    = 20;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int STORE_SLOTS    = INDEX_LIMIT / 2;
	localparam int DEPTH_CAP      = (DEFAULT_MAX_DEPTH < INDEX_LIMIT) ? DEFAULT_MAX_DEPTH
		: INDEX_LIMIT;
	localparam int DIR_ROWS       = 37;
	localparam int PHASES         = 6;

	typedef struct packed {
		logic signed [15:0] x;
		logic signed [15:0] sn;
		logic signed [15:0] cs;
		logic [15:0]        off;
	} elem_item_t;

	typedef struct packed {
		logic signed [15:0] value;
		logic [7:0]         index;
		logic [15:0]        tindex;
		logic               last;
	} rope_result_t;

	// One row of the directed table: either a register write or an element.
	typedef struct packed {
		bit                 is_cfg;
		reg_idx_t           addr_sel;
		int                 val;
		elem_item_t         item;
		int                 n_typed;
		logic signed [15:0] t0;
		logic signed [15:0] t1;
	} dir_row_t;

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic pready;

	rope_in_if  elem_ch ();
	rope_out_if res_ch ();

	rotary_position_embedding_stream u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.elem    (elem_ch),
		.result  (res_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// Shadow of the block's registers and counters.
	cfg_t shadow_cfg;
	int elem_idx;
	int row_time;
	logic signed [15:0] partner_val [STORE_SLOTS];
	logic signed [15:0] partner_sin [STORE_SLOTS];
	logic signed [15:0] partner_cos [STORE_SLOTS];
	bit partner_written [STORE_SLOTS];
	logic [15:0] row_base_off;

	rope_result_t item_results [$];
	rope_result_t pending_results [$];

	int errors;
	int results_checked;
	int directed_items;
	int random_items;
	int quiet_cycles;
	int send_gap_pct;
	int sink_stall_pct;

	dir_row_t directed_rows [DIR_ROWS] = '{
		'{1'b0, REG_STEP, 0, '{16'sd1234, 16'sd0, 16'sd16384, 16'd0}, 0, 16'sd0, 16'sd0},
		'{1'b0, REG_STEP, 0, '{16'sd5, 16'sd0, 16'sd16384, 16'd1}, 0, 16'sd0, 16'sd0},
		'{1'b0, REG_STEP, 0, '{16'sd7, 16'sd3, 16'sd100, 16'd0}, BY_PREDICTOR, 16'sd0, 16'sd0},
		'{1'b1, REG_DEPTH, 511, '{16'sd0, 16'sd0, 16'sd0, 16'd0}, 0, 16'sd0, 16'sd0},
		'{1'b1, REG_WIDTH, 3, '{16'sd0, 16'sd0, 16'sd0, 16'd0}, 0, 16'sd0, 16'sd0},
		'{1'b0, REG_STEP, 0, '{16'sh8000, 16'sd0, 16'sd0, 16'd0}, 1, 16'sh8000, 16'sd0},
		'{1'b1, REG_DEPTH, 2, '{16'sd0, 16'sd0, 16'sd0, 16'd0}, 0, 16'sd0, 16'sd0},
		'{1'b0, REG_STEP, 0, '{16'sh7fff, 16'sd0, 16'sd0, 16'd0}, 1, 16'sh7fff, 16'sd0},
		'{1'b1, REG_ROWS, 3, '{16'sd0, 16'sd0, 16'sd0, 16'd0}, 0, 16'sd0, 16'sd0},
		'{1'b0, REG_STEP, 0, '{16'sd1000, 16'sd0, 16'sd16384, 16'd0}, BY_PREDICTOR,
			16'sd0, 16'sd0},
		'{1'b0, REG_STEP, 0, '{-16'sd2000, 16'sd0, 16'sd16384, 16'd0}, 2,
			16'sd1000, -16'sd2000},
		'{1'b0, REG_STEP, 0, '{16'sh7fff, 16'sd16384, 16'sd16384, 16'd0}, BY_PREDICTOR,
			16'sd0, 16'sd0},
		'{1'b0, REG_STEP, 0, '{16'sh7fff, 16'sd16384, 16'sd16384, 16'd0}, 2,
			16'sd0, 16'sh7fff},
		'{1'b0, REG_STEP, 0, '{16'sh8000, -16'sd16384, -16'sd16384, 16'd0}, BY_PREDICTOR,
			16'sd0, 16'sd0},
		'{1'b0, REG_STEP, 0, '{16'sh8000, 16'sd16384, 16'sd16384, 16'd0}, 2,
			16'sd0, 16'sh8000},
		'{1'b0, REG_STEP, 0, '{16'sd1, 16'sd0, 16'sd8192, 16'd0}, BY_PREDICTOR, 16'sd0, 16'sd0},
		'{1'b0, REG_STEP, 0, '{-16'sd1, 16'sd0, 16'sd8192, 16'd0}, 2, 16'sd1, 16'sd0},
		'{1'b0, REG_STEP, 0, '{16'sd11, 16'sd0, 16'sd16384, 16'd2}, 0, 16'sd0, 16'sd0},
		'{1'b0, REG_STEP, 0, '{16'sd22, 16'sd0, 16'sd16384, 16'd2}, 0, 16'sd0, 16'sd0},
		'{1'b1, REG_ROWS, 0, '{16'sd0, 16'sd0, 16'sd0, 16'd0}, 0, 16'sd0, 16'sd0},
		'{1'b1, REG_STEP, 65535, '{16'sd0, 16'sd0, 16'sd0, 16'd0}, 0, 16'sd0, 16'sd0},
		'{1'b1, REG_MODE, 1, '{16'sd0, 16'sd0, 16'sd0, 16'd0}, 0, 16'sd0, 16'sd0},
		'{1'b1, REG_DEPTH, 6, '{16'sd0, 16'sd0, 16'sd0, 16'd0}, 0, 16'sd0, 16'sd0},
		'{1'b1, REG_WIDTH, 0, '{16'sd0, 16'sd0, 16'sd0, 16'd0}, 0, 16'sd0, 16'sd0},
		'{1'b0, REG_STEP, 0, '{16'sd100, 16'sd3000, -16'sd9000, 16'hffff}, BY_PREDICTOR,
			16'sd0, 16'sd0},
		'{1'b0, REG_STEP, 0, '{-16'sd250, 16'sd16384, 16'sd0, 16'hffff}, BY_PREDICTOR,
			16'sd0, 16'sd0},
		'{1'b0, REG_STEP, 0, '{16'sh7fff, -16'sd16384, 16'sd16384, 16'hffff}, BY_PREDICTOR,
			16'sd0, 16'sd0},
		'{1'b0, REG_STEP, 0, '{16'sh8000, 16'sd12000, -16'sd12000, 16'hffff}, BY_PREDICTOR,
			16'sd0, 16'sd0},
		'{1'b0, REG_STEP, 0, '{16'sd4096, 16'sd0, 16'sd0, 16'hffff}, BY_PREDICTOR,
			16'sd0, 16'sd0},
		'{1'b0, REG_STEP, 0, '{-16'sd7, -16'sd1, 16'sd1, 16'hffff}, BY_PREDICTOR,
			16'sd0, 16'sd0},
		'{1'b1, REG_WIDTH, 5, '{16'sd0, 16'sd0, 16'sd0, 16'd0}, 0, 16'sd0, 16'sd0},
		'{1'b1, REG_DEPTH, 5, '{16'sd0, 16'sd0, 16'sd0, 16'd0}, 0, 16'sd0, 16'sd0},
		'{1'b0, REG_STEP, 0, '{16'sd300, 16'sd5000, 16'sd15000, 16'd0}, BY_PREDICTOR,
			16'sd0, 16'sd0},
		'{1'b0, REG_STEP, 0, '{-16'sd300, -16'sd5000, 16'sd15000, 16'd0}, BY_PREDICTOR,
			16'sd0, 16'sd0},
		'{1'b0, REG_STEP, 0, '{16'sd20000, 16'sd16384, -16'sd16384, 16'd0}, BY_PREDICTOR,
			16'sd0, 16'sd0},
		'{1'b0, REG_STEP, 0, '{-16'sd20000, -16'sd8, 16'sd9, 16'd0}, BY_PREDICTOR,
			16'sd0, 16'sd0},
		'{1'b0, REG_STEP, 0, '{16'sd12345, 16'sd0, 16'sd16384, 16'd0}, BY_PREDICTOR,
			16'sd0, 16'sd0}
	};

	// Random phases: register settings and element budget of each.
	cfg_t phase_cfg [PHASES] = '{
		'{16'd0,     9'd0,   9'd0,   16'd1,     1'b0},
		'{16'd3,     9'd6,   9'd4,   16'd3,     1'b1},
		'{16'd65535, 9'd256, 9'd511, 16'd65535, 1'b0},
		'{16'd21845, 9'd9,   9'd7,   16'd4,     1'b0},
		'{16'd10,    9'd16,  9'd300, 16'd5,     1'b1},
		'{16'd0,     9'd12,  9'd8,   16'd2,     1'b0}
	};
	int phase_items [PHASES] = '{40, 60, 256, 60, 60, 60};

	function automatic void eff_geometry(output int depth, output int width);
		depth = int'(shadow_cfg.depth);
		if (depth < 2) depth = 2;
		if (depth > DEPTH_CAP) depth = DEPTH_CAP;
		width = (shadow_cfg.width == 0 || int'(shadow_cfg.width) > depth) ? depth
			: int'(shadow_cfg.width);
		width -= width % 2;
	endfunction

	// own*cos + sign*partner*sin, rounded half up at bit 14, then saturated.
	function automatic logic signed [15:0] rotate_q14(logic signed [15:0] own, partner, sn, cs,
		bit lower);
		longint acc;
		acc = longint'(own) * longint'(cs)
			+ (lower ? -longint'(partner) : longint'(partner)) * longint'(sn) + ROUND_BIAS;
		acc = acc >>> FRAC_BITS;
		if (acc > 32767) return 16'sh7fff;
		if (acc < -32768) return 16'sh8000;
		return 16'(acc);
	endfunction

	// Computes the results of one element into item_results and advances the counters.
	task automatic rope_predict(input elem_item_t it);
		int depth, width, half, rows, pos, j;
		eff_geometry(depth, width);
		half = width / 2;
		rows = (shadow_cfg.rows == 0) ? 1 : int'(shadow_cfg.rows);
		pos = row_time - int'(it.off) + int'(shadow_cfg.step);
		item_results.delete();
		if (pos >= 0) begin
			if (elem_idx >= width) begin
				item_results.push_back('{it.x, 8'(elem_idx), 16'(row_time), 1'b1});
			end else if (shadow_cfg.interleave && elem_idx % 2 == 0 ||
				!shadow_cfg.interleave && elem_idx < half) begin
				j = shadow_cfg.interleave ? 0 : elem_idx;
				partner_val[j] = it.x;
				partner_sin[j] = it.sn;
				partner_cos[j] = it.cs;
				partner_written[j] = 1'b1;
			end else begin
				j = shadow_cfg.interleave ? 0 : elem_idx - half;
				item_results.push_back('{rotate_q14(partner_val[j], it.x, partner_sin[j],
					partner_cos[j], 1'b1), 8'(shadow_cfg.interleave ? elem_idx - 1 : j),
					16'(row_time), 1'b0});
				item_results.push_back('{rotate_q14(it.x, partner_val[j], it.sn, it.cs, 1'b0),
					8'(elem_idx), 16'(row_time), 1'b1});
			end
		end
		if (elem_idx + 1 >= depth) begin
			elem_idx = 0;
			row_time = (row_time + 1 >= rows) ? 0 : row_time + 1;
		end else begin
			elem_idx = elem_idx + 1;
		end
	endtask

	function automatic logic signed [15:0] rand_trig();
		case ($urandom_range(0, 9))
			0: return 16'sd16384;
			1: return -16'sd16384;
			2: return 16'sd0;
			default: return 16'($urandom_range(0, 32768)) - 16'sd16384;
		endcase
	endfunction

	function automatic elem_item_t rand_elem();
		elem_item_t it;
		int depth, width, reach;
		eff_geometry(depth, width);
		reach = row_time + int'(shadow_cfg.step);
		// Pick the row's offset at its first element: mostly a live row, sometimes a padded one.
		if (elem_idx == 0) begin
			case ($urandom_range(0, 9))
				0: row_base_off = (reach < 65535) ? 16'($urandom_range(reach + 1, 65535))
					: 16'($urandom);
				1: row_base_off = 16'($urandom);
				default: row_base_off = 16'($urandom_range(0, (reach > 65535) ? 65535 : reach));
			endcase
		end
		case ($urandom_range(0, 9))
			0: it.x = 16'sh7fff;
			1: it.x = 16'sh8000;
			default: it.x = 16'($urandom);
		endcase
		it.sn = rand_trig();
		it.cs = rand_trig();
		it.off = ($urandom_range(0, 9) == 0) ? 16'($urandom) : row_base_off;
		// An upper element must never pair with a slot that has not been written yet;
		// the largest offset drops it, since its lower half was dropped the same way.
		if (reach - int'(it.off) >= 0 && elem_idx < width &&
			(shadow_cfg.interleave ? (elem_idx % 2 == 1 && !partner_written[0])
			: (elem_idx >= width / 2 && !partner_written[elem_idx - width / 2])))
			it.off = 16'hffff;
		return it;
	endfunction

	task automatic send_elem(input elem_item_t it, input int n_typed,
		input logic signed [15:0] t0, input logic signed [15:0] t1);
		@(negedge clk);
		if ($urandom_range(0, 99) < send_gap_pct) begin
			elem_ch.valid = 1'b0;
			do @(negedge clk); while ($urandom_range(0, 99) < send_gap_pct);
		end
		elem_ch.elem_value   = it.x;
		elem_ch.sine_value   = it.sn;
		elem_ch.cosine_value = it.cs;
		elem_ch.row_offset   = it.off;
		elem_ch.valid        = 1'b1;
		do @(posedge clk); while (!elem_ch.ready);
		rope_predict(it);
		if (n_typed != BY_PREDICTOR) begin
			if (item_results.size() != n_typed) begin
				errors++;
				$display("%0t: directed element expected %0d results, predictor gives %0d",
					$time, n_typed, item_results.size());
			end
			if (item_results.size() > 0) item_results[0].value = t0;
			if (item_results.size() > 1) item_results[1].value = t1;
		end
		foreach (item_results[k]) pending_results.push_back(item_results[k]);
	endtask

	// Registers change only once the block has drained and settled.
	task automatic write_reg(input reg_idx_t idx, input logic [31:0] value);
		@(negedge clk);
		elem_ch.valid = 1'b0;
		while (pending_results.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = 1'b1;
		paddr   = PADDR_W'(int'(idx) * 4);
		pwdata  = value;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			REG_STEP:  shadow_cfg.step = value[15:0];
			REG_DEPTH: shadow_cfg.depth = value[8:0];
			REG_WIDTH: shadow_cfg.width = value[8:0];
			REG_ROWS:  shadow_cfg.rows = value[15:0];
			REG_MODE:  shadow_cfg.interleave = value[0];
			default: ;
		endcase
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
	endtask

	task automatic check_field(input string name, input longint want, input longint got);
		if (want != got) begin
			errors++;
			$display("%0t: %s expected %0d got %0d", $time, name, want, got);
		end
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(negedge clk) res_ch.ready = ($urandom_range(0, 99) >= sink_stall_pct);

	always @(posedge clk) begin
		rope_result_t want;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (pending_results.size() == 0) begin
				errors++;
				$display("%0t: result with none expected, got value %0d index %0d time %0d",
					$time, res_ch.out_value, res_ch.element_index, res_ch.time_index);
			end else begin
				want = pending_results.pop_front();
				results_checked++;
				check_field("out_value", want.value, res_ch.out_value);
				check_field("element_index", want.index, res_ch.element_index);
				check_field("time_index", want.tindex, res_ch.time_index);
				check_field("last_of_run", want.last, res_ch.last_of_run);
			end
		end
	end

	always @(posedge clk) begin
		if ((elem_ch.valid && elem_ch.ready) || (res_ch.valid && res_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin
		while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clk);
		$display("%0t: no transaction for %0d cycles, %0d results still expected", $time,
			WATCHDOG_LIMIT, pending_results.size());
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		arst_n               = 1'b0;
		psel                 = 1'b0;
		penable              = 1'b0;
		pwrite               = 1'b0;
		paddr                = '0;
		pwdata               = '0;
		elem_ch.valid        = 1'b0;
		elem_ch.elem_value   = '0;
		elem_ch.sine_value   = '0;
		elem_ch.cosine_value = '0;
		elem_ch.row_offset   = '0;
		res_ch.ready         = 1'b0;
		quiet_cycles         = 0;
		errors               = 0;
		results_checked      = 0;
		directed_items       = 0;
		random_items         = 0;
		row_base_off         = '0;
		shadow_cfg           = '{RST_STEP, RST_DEPTH, RST_WIDTH, RST_ROWS, RST_MODE};
		elem_idx             = 0;
		row_time             = 0;
		foreach (partner_written[k]) partner_written[k] = 1'b0;
		send_gap_pct         = 20;
		sink_stall_pct       = 82;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (directed_rows[k]) begin
			if (directed_rows[k].is_cfg) begin
				write_reg(directed_rows[k].addr_sel, directed_rows[k].val);
			end else begin
				send_elem(directed_rows[k].item, directed_rows[k].n_typed,
					directed_rows[k].t0, directed_rows[k].t1);
				directed_items++;
			end
		end

		// Each phase is padded out to a row boundary before the registers change.
		foreach (phase_cfg[p]) begin
			if (p == 2) begin
				send_gap_pct   = 82;
				sink_stall_pct = 20;
			end else if (p == 4) begin
				send_gap_pct   = 0;
				sink_stall_pct = 0;
			end
			write_reg(REG_STEP, phase_cfg[p].step);
			write_reg(REG_DEPTH, phase_cfg[p].depth);
			write_reg(REG_WIDTH, phase_cfg[p].width);
			write_reg(REG_ROWS, phase_cfg[p].rows);
			write_reg(REG_MODE, phase_cfg[p].interleave);
			for (int k = 0; k < phase_items[p] || elem_idx != 0; k++) begin
				send_elem(rand_elem(), BY_PREDICTOR, 16'sd0, 16'sd0);
				random_items++;
			end
		end

		@(negedge clk);
		elem_ch.valid = 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("Sent %0d directed and %0d random elements over %0d register settings,",
			directed_items, random_items, PHASES + 1);
		$display("checked %0d results with %0d mismatches.", results_checked, errors);
		if (errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
